// ===== design/rp_pkg.sv =====
// Shared types and constants for the range progression add / point query block.
`timescale 1ns / 1ps

package rp_pkg;

   // Field widths and offsets of the request tdata bus
   localparam int unsigned POS_W     = 11;
   localparam int unsigned TERM_W    = 32;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned START_LSB = 0;
   localparam int unsigned END_LSB   = 11;
   localparam int unsigned FIRST_LSB = 22;
   localparam int unsigned STEP_LSB  = 54;
   localparam int unsigned POS_LSB   = 86;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_ELEMENT_COUNT = 1'b0;

   // Request kinds carried on tuser
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_PREP,
      ST_U_SET,
      ST_U_RD,
      ST_U_WR,
      ST_Q_RD,
      ST_Q_ACC,
      ST_Q_MUL,
      ST_Q_FIN
   } state_type;

endpackage

// ===== design/rp_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rp_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/range_progression_add_point_query.sv =====
// Top level: request sequencer, Fenwick tree walk over node RAM, and CSR port.
`timescale 1ns / 1ps

// The sequence is held as two Fenwick trees in one node RAM (entry = slope sum
// in the upper 64 bits, offset sum in the lower), so value(p) = p*slope + offset.
// A progression add makes at most two point edits, each a walk of up to
// log2(MAX_ELEMENTS)+1 read-modify-write steps (ST_U_RD, then ST_U_WR) on the
// RAM port, after the setup states ST_U_PREP and ST_U_SET. A query walks at
// most log2(N)+1 levels, each a read (ST_Q_RD) and an accumulate (ST_Q_ACC),
// then multiplies (ST_Q_MUL) and sums (ST_Q_FIN), and waits in ST_Q_FIN while
// a prior result is still unaccepted on the response channel. One request is
// worked on at a time; the next one is taken once the walk finishes, while a
// prior result may still wait on the response channel.
// After reset a clearing pass writes zero to all MAX_ELEMENTS entries, one per
// cycle; no request is taken during the clearing pass.
module range_progression_add_point_query #(
   parameter int unsigned MAX_ELEMENTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: range_start[10:0], range_end[21:11], first_term[53:22],
   //        step[85:54], position[96:86], zero fill[103:97]
   input  logic [rp_pkg::REQ_DATA_W-1:0]         req_tdata,
   // tuser: func[0]
   input  logic                                  req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: value[63:0]
   output logic [rp_pkg::VALUE_W-1:0]            rsp_tdata,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rp_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [rp_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [rp_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned FW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned VW = rp_pkg::VALUE_W;
   localparam int unsigned PW = rp_pkg::POS_W;
   localparam int unsigned TW = rp_pkg::TERM_W;

   rp_pkg::state_type state_ff, state_in;

   logic [AW-1:0]        clr_ff, clr_in;
   logic [FW-1:0]        count_ff, count_in;
   logic [PW-1:0]        l_ff, l_in, r_ff, r_in;
   logic signed [TW-1:0] k_ff, k_in, d_ff, d_in;
   logic [FW-1:0]        p_ff, p_in;
   logic [VW-1:0]        prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic [FW-1:0]        idx_ff, idx_in, idx2_ff, idx2_in;
   logic [VW-1:0]        dx_ff, dx_in, dy_ff, dy_in, dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic                 has2_ff, has2_in;
   logic [VW-1:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic [FW+31:0]       mlo_ff, mlo_in;
   logic [31:0]          mhi_ff, mhi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [2*VW-1:0]      ram_wdata, ram_rdata;

   logic signed [TW+PW:0] mul_l, mul_r;
   logic [FW-1:0]         lowbit;
   logic [FW:0]           idx_up;
   logic [FW-1:0]         idx_dn;
   logic [VW-1:0]         offs;
   logic [31:0]           p_sat;
   logic                  req_fire, csr_wr, upd_bad;

   // Node RAM
   rp_ram #(
      .DEPTH(MAX_ELEMENTS),
      .WIDTH(2 * VW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == rp_pkg::REG_ELEMENT_COUNT) ? 32'(count_ff) : '0;

   always_comb begin
      count_in = count_ff;
      if (csr_wr && csr_paddr[2] == rp_pkg::REG_ELEMENT_COUNT) begin
         if (csr_pwdata[10:0] == 11'd0) begin
            count_in = FW'(1);
         end else if (32'(csr_pwdata[10:0]) > 32'(MAX_ELEMENTS)) begin
            count_in = FW'(MAX_ELEMENTS);
         end else begin
            count_in = FW'(csr_pwdata[10:0]);
         end
      end
   end

   // Datapath helpers
   assign mul_l   = (TW+PW+1)'($signed({1'b0, l_ff})) * (TW+PW+1)'(d_ff);
   assign mul_r   = (TW+PW+1)'($signed({1'b0, r_ff})) * (TW+PW+1)'(d_ff);
   assign lowbit  = idx_ff & (~idx_ff + FW'(1));
   assign idx_up  = {1'b0, idx_ff} + {1'b0, lowbit};
   assign idx_dn  = idx_ff - lowbit;
   assign offs    = {{(VW-TW){k_ff[TW-1]}}, k_ff} - prod_l_ff;
   assign p_sat   = (32'(req_tdata[rp_pkg::POS_LSB +: PW]) > 32'(count_ff)) ?
                    32'(count_ff) : 32'(req_tdata[rp_pkg::POS_LSB +: PW]);
   assign req_fire = req_tvalid & req_tready;
   assign upd_bad = (l_in == '0) || (l_in > r_in) || (32'(r_in) > 32'(count_ff));

   assign ram_raddr = AW'(idx_ff - FW'(1));
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      idx_in       = idx_ff;
      idx2_in      = idx2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      has2_in      = has2_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = AW'(idx_ff - FW'(1));
      ram_wdata    = {dx_ff + ram_rdata[2*VW-1:VW], dy_ff + ram_rdata[VW-1:0]};

      // Latch request fields whenever the block is waiting for one
      if (state_ff == rp_pkg::ST_IDLE) begin
         l_in    = req_tdata[rp_pkg::START_LSB +: PW];
         r_in    = req_tdata[rp_pkg::END_LSB +: PW];
         k_in    = req_tdata[rp_pkg::FIRST_LSB +: TW];
         d_in    = req_tdata[rp_pkg::STEP_LSB +: TW];
         p_in    = FW'(p_sat);
      end

      unique case (state_ff)
         rp_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (32'(clr_ff) == 32'(MAX_ELEMENTS - 1)) begin
               state_in = rp_pkg::ST_IDLE;
            end
         end
         rp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (req_tuser == rp_pkg::FUNC_QUERY) begin
                  sx_in  = '0;
                  sy_in  = '0;
                  idx_in = FW'(p_sat);
                  if (p_sat == 32'd0) begin
                     mlo_in   = '0;
                     mhi_in   = '0;
                     state_in = rp_pkg::ST_Q_FIN;
                  end else begin
                     state_in = rp_pkg::ST_Q_RD;
                  end
               end else if (!upd_bad) begin
                  state_in = rp_pkg::ST_U_PREP;
               end
            end
         end
         rp_pkg::ST_U_PREP: begin
            prod_l_in = {{(VW-TW-PW-1){mul_l[TW+PW]}}, mul_l};
            prod_r_in = {{(VW-TW-PW-1){mul_r[TW+PW]}}, mul_r};
            state_in  = rp_pkg::ST_U_SET;
         end
         rp_pkg::ST_U_SET: begin
            // Slope edit +d at l, offset edit k-l*d; closing edit at r+1 if within MAX_ELEMENTS
            idx_in  = FW'(l_ff);
            dx_in   = {{(VW-TW){d_ff[TW-1]}}, d_ff};
            dy_in   = offs;
            idx2_in = FW'(32'(r_ff) + 32'd1);
            dx2_in  = '0 - {{(VW-TW){d_ff[TW-1]}}, d_ff};
            dy2_in  = (32'(r_ff) + 32'd1 <= 32'(count_ff)) ? ('0 - offs) : prod_r_ff;
            has2_in = (32'(r_ff) + 32'd1 <= 32'(MAX_ELEMENTS));
            state_in = rp_pkg::ST_U_RD;
         end
         rp_pkg::ST_U_RD: begin
            ram_re   = 1'b1;
            state_in = rp_pkg::ST_U_WR;
         end
         rp_pkg::ST_U_WR: begin
            ram_we = 1'b1;
            if (32'(idx_up) <= 32'(MAX_ELEMENTS)) begin
               idx_in   = FW'(idx_up);
               state_in = rp_pkg::ST_U_RD;
            end else if (has2_ff) begin
               idx_in   = idx2_ff;
               dx_in    = dx2_ff;
               dy_in    = dy2_ff;
               has2_in  = 1'b0;
               state_in = rp_pkg::ST_U_RD;
            end else begin
               state_in = rp_pkg::ST_IDLE;
            end
         end
         rp_pkg::ST_Q_RD: begin
            ram_re   = 1'b1;
            state_in = rp_pkg::ST_Q_ACC;
         end
         rp_pkg::ST_Q_ACC: begin
            sx_in  = sx_ff + ram_rdata[2*VW-1:VW];
            sy_in  = sy_ff + ram_rdata[VW-1:0];
            idx_in = idx_dn;
            if (idx_dn == '0) begin
               state_in = rp_pkg::ST_Q_MUL;
            end else begin
               state_in = rp_pkg::ST_Q_RD;
            end
         end
         rp_pkg::ST_Q_MUL: begin
            // p * slope modulo 2^64, split into 32-bit halves
            mlo_in   = (FW+32)'(p_ff) * (FW+32)'(sx_ff[31:0]);
            mhi_in   = sx_ff[63:32] * 32'(p_ff);
            state_in = rp_pkg::ST_Q_FIN;
         end
         rp_pkg::ST_Q_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = VW'(mlo_ff) + {mhi_ff, 32'd0} + sy_ff;
               state_in     = rp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= FW'(MAX_ELEMENTS);
         rsp_valid_ff <= 1'b0;
         has2_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         has2_ff      <= has2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      idx_ff      <= idx_in;
      idx2_ff     <= idx2_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dx2_ff      <= dx2_in;
      dy2_ff      <= dy2_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      mlo_ff      <= mlo_in;
      mhi_ff      <= mhi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench for the range progression add / point query block.
`timescale 1ns / 1ps

// Mirror of the sequence: a plain difference array, summed on each query.
class rp_scoreboard;
   longint unsigned diff_at[1:1024];
   int unsigned     elem_count = 1024;
   longint unsigned queued_values[$];
   int unsigned     errors = 0;

   // saturate a written count into 1..1024
   function void write_count(bit [31:0] v);
      int unsigned c;
      c = v & 32'h7FF;
      if (c < 1) c = 1;
      if (c > 1024) c = 1024;
      elem_count = c;
   endfunction

   function void note_request(bit func, bit [10:0] l, bit [10:0] r,
                              bit [31:0] k, bit [31:0] d, bit [10:0] p);
      longint unsigned ks, ds, acc;
      int unsigned     pos;
      ks = {{32{k[31]}}, k};
      ds = {{32{d[31]}}, d};
      if (func == rp_pkg::FUNC_ADD) begin
         // drop bad ranges
         if (l < 1 || l > r || r > elem_count) return;
         diff_at[l] += ks;
         for (int i = l + 1; i <= r; i++) diff_at[i] += ds;
         if (r + 1 <= elem_count)
            diff_at[r + 1] -= ks + longint'(r - l) * ds;
      end else begin
         pos = (p > elem_count) ? elem_count : p;
         acc = 0;
         for (int i = 1; i <= pos; i++) acc += diff_at[i];
         queued_values.push_back(acc);
      end
   endfunction

   function void check_value(logic [63:0] got);
      longint unsigned want;
      if (queued_values.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = queued_values.pop_front();
      if (got !== want) begin
         $display("%0t: value mismatch, expected %h, actual %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb;

   logic                                  clock = 0;
   logic                                  reset = 1;
   logic                                  req_tvalid = 0;
   logic                                  req_tready;
   logic [rp_pkg::REQ_DATA_W-1:0]         req_tdata = '0;
   logic                                  req_tuser = rp_pkg::FUNC_ADD;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 0;
   logic [rp_pkg::VALUE_W-1:0]            rsp_tdata;
   logic                                  csr_psel = 0;
   logic                                  csr_penable = 0;
   logic                                  csr_pwrite = 0;
   logic [rp_pkg::CSR_ADDR_W-1:0]         csr_paddr = '0;
   logic [rp_pkg::CSR_DATA_W-1:0]         csr_pwdata = '0;
   logic [rp_pkg::CSR_DATA_W-1:0]         csr_prdata;
   logic                                  csr_pready;

   rp_scoreboard sb = new;
   int unsigned  req_idle_pct = 17;
   int unsigned  rsp_idle_pct = 60;
   int unsigned  rsp_hold = 0;

   localparam logic [rp_pkg::CSR_ADDR_W-1:0] ADDR_COUNT = 3'd0;
   localparam logic [rp_pkg::CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

   range_progression_add_point_query u_top (.*);

   always #5 clock = ~clock;

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_value(rsp_tdata);
   end

   task automatic send_item(bit func, bit [10:0] l, bit [10:0] r,
                            bit [31:0] k, bit [31:0] d, bit [10:0] p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {7'b0, p, d, k, r, l};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, l, r, k, d, p);
   endtask

   // drain, then write a register with a setup phase and then an access phase
   task automatic write_reg(logic [rp_pkg::CSR_ADDR_W-1:0] addr, logic [31:0] v);
      req_tvalid <= 1'b0;
      while (sb.queued_values.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_COUNT) sb.write_count(v);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // mostly well-formed adds and in-range queries, some noise
   task automatic random_items(int unsigned n);
      bit [10:0] l, r, p;
      int unsigned ec;
      for (int i = 0; i < n; i++) begin
         ec = sb.elem_count;
         if ($urandom_range(9) < 8) begin
            l = 11'($urandom_range(ec, 1));
            r = ($urandom_range(3) == 0) ? l : 11'($urandom_range(ec, l));
            p = 11'($urandom_range(ec, 0));
         end else begin
            l = 11'($urandom);
            r = 11'($urandom);
            p = 11'($urandom);
         end
         if ($urandom_range(3) == 0) begin
            // point load
            send_item(rp_pkg::FUNC_ADD, l, l, $urandom, 32'd0, p);
         end else begin
            send_item(1'($urandom_range(1)), l, r, $urandom, $urandom, p);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_reg(ADDR_COUNT, 32'd1024);

      // directed: extremes, bad ranges, query at zero and past count
      send_item(rp_pkg::FUNC_ADD, 11'd1, 11'd1024, 32'h7FFF_FFFF, 32'h8000_0000, 11'd0);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd0);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd1);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd1024);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'h7FF);
      send_item(rp_pkg::FUNC_ADD, 11'd5, 11'd900, 32'h8000_0000, 32'h7FFF_FFFF, 11'h7FF);
      send_item(rp_pkg::FUNC_ADD, 11'd1, 11'd1, 32'hFFFF_FFFF, 32'd0, 11'd0);
      send_item(rp_pkg::FUNC_ADD, 11'd1024, 11'd1024, 32'd12345, 32'd0, 11'd0);
      send_item(rp_pkg::FUNC_ADD, 11'd0, 11'd10, 32'd7, 32'd3, 11'd0);
      send_item(rp_pkg::FUNC_ADD, 11'd20, 11'd10, 32'd7, 32'd3, 11'd0);
      send_item(rp_pkg::FUNC_ADD, 11'd1, 11'h7FF, 32'd7, 32'd3, 11'd0);
      send_item(rp_pkg::FUNC_ADD, 11'h7FF, 11'h7FF, 32'd7, 32'd3, 11'd0);
      send_item(rp_pkg::FUNC_QUERY, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd5);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd6);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd901);
      send_item(rp_pkg::FUNC_QUERY, 11'd0, 11'd0, 32'd0, 32'd0, 11'd1023);

      random_items(150);
      // long receiver hold-off while requests keep coming
      rsp_hold = 400;
      random_items(150);

      // smallest count: a written zero saturates to one
      write_reg(ADDR_COUNT, 32'd0);
      random_items(60);
      // shrink, then raise again to expose kept differences
      write_reg(ADDR_COUNT, 32'd37);
      random_items(120);
      write_reg(ADDR_UNUSED, 32'd5);
      random_items(40);
      req_idle_pct = 60;
      rsp_idle_pct = 17;
      write_reg(ADDR_COUNT, 32'hFFFF_FFFF);
      random_items(180);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(ADDR_COUNT, 32'd1024);
      random_items(200);

      // drain
      req_tvalid <= 1'b0;
      while (sb.queued_values.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
